/* rtl/dmxd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the DMX slot capture / PWM dimmer.
// No dependencies; the core, front end, queue, back end and testbench import this package.
package dmxd_pkg;

  localparam int unsigned MAX_CHANNELS      = 16;
  localparam int unsigned CH_IDX_W          = $clog2(MAX_CHANNELS);
  localparam int unsigned SLOT_W            = 10;
  localparam int unsigned LEVEL_W           = 8;
  localparam int unsigned LAST_SLOT         = 512;
  localparam int unsigned SLOT_SATURATE     = 513;
  localparam int unsigned PHASE_TOP         = 255;
  localparam int unsigned START_RESET       = 1;
  localparam int unsigned CHANNEL_COUNT_DEF = 3;
  localparam int unsigned QUEUE_DEPTH_DEF   = 2;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_BREAK,
    OP_BYTE
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [LEVEL_W-1:0]  data;
    logic                cap_en;
    logic [CH_IDX_W-1:0] cap_idx;
    logic [SLOT_W-1:0]   slot;
  } cmd_t;

endpackage

/* rtl/dmxd_in_if.sv */
`timescale 1ns / 1ps
// Input channel of the dimmer: serial bytes with receiver flags, or PWM ticks.
// Valid/ready handshake; no dependencies.
interface dmxd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  logic       frame_error;
  logic       overrun;

  modport source(output valid, output req_type, output rx_byte, output frame_error,
                 output overrun, input ready);
  modport sink(input valid, input req_type, input rx_byte, input frame_error,
               input overrun, output ready);
endinterface

/* rtl/dmxd_out_if.sv */
`timescale 1ns / 1ps
// Result channel of the dimmer: drive bits, latched levels and slot counter.
// Valid/ready handshake; no dependencies.
interface dmxd_out_if;
  logic       valid;
  logic       ready;
  logic       drive_one;
  logic       drive_two;
  logic       drive_three;
  logic [7:0] level_one;
  logic [7:0] level_two;
  logic [7:0] level_three;
  logic [9:0] slot_position;

  modport source(output valid, output drive_one, output drive_two, output drive_three,
                 output level_one, output level_two, output level_three,
                 output slot_position, input ready);
  modport sink(input valid, input drive_one, input drive_two, input drive_three,
               input level_one, input level_two, input level_three,
               input slot_position, output ready);
endinterface

/* rtl/dmx_slot_capture_pwm_dimmer_core.sv */
`timescale 1ns / 1ps
// DMX512 slot capture with a PWM dimmer, top level.
// in_ch carries either a received serial byte with its framing-error and
// overrun flags, or one PWM tick; out_ch returns one result beat per input
// beat: the three drive bits, the three latched levels and the slot counter,
// all as they stand after that input.
// cfg_wr_en/cfg_wr_data write the start address (first captured slot); write
// it only while no beat is in flight.
// A result passes through the queue entry written when its input beat is taken, then
// through the back-end update into the output register. Throughput: one beat per cycle
// while out_ch is ready, limited by the single back-end update per cycle.
// When out_ch stalls, the output register holds its beat and the command queue (QUEUE_DEPTH
// entries, two by default) absorbs further inputs; in_ch.ready drops once it is full.
// Reset (rst_n low, synchronous) clears the slot counter, levels, PWM phase and
// drives, empties the queue and sets the start address to 1.
// Depends on dmxd_pkg, dmxd_in_if, dmxd_out_if, dmxd_front, dmxd_queue, dmxd_back.
module dmx_slot_capture_pwm_dimmer_core #(
  parameter int unsigned CHANNEL_COUNT = dmxd_pkg::CHANNEL_COUNT_DEF,
  parameter int unsigned QUEUE_DEPTH   = dmxd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [dmxd_pkg::SLOT_W-1:0] cfg_wr_data,
  dmxd_in_if.sink                     in_ch,
  dmxd_out_if.source                  out_ch
);
  import dmxd_pkg::*;

  logic push;
  logic pop;
  logic q_valid;
  logic q_full;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  dmxd_front #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  dmxd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .q_valid (q_valid),
    .q_full  (q_full),
    .pop_cmd (pop_cmd)
  );

  dmxd_back #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .cmd    (pop_cmd),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

/* rtl/dmxd_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input beats, tracks the DMX slot counter and start address,
// and turns each beat into a command for the queue. Uses dmxd_pkg, dmxd_in_if.
module dmxd_front #(
  parameter int unsigned CHANNEL_COUNT = dmxd_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  dmxd_in_if.sink                     in_ch,
  input  logic                        cfg_wr_en,
  input  logic [dmxd_pkg::SLOT_W-1:0] cfg_wr_data,
  input  logic                        q_full,
  output logic                        push,
  output dmxd_pkg::cmd_t              cmd
);
  import dmxd_pkg::*;

  logic [SLOT_W-1:0] start_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  logic [SLOT_W-1:0] start_eff;
  logic [SLOT_W:0]   diff;
  logic              in_window;
  logic              brk;

  always_comb begin
    if (start_r == '0) begin
      start_eff = SLOT_W'(1);
    end else if (start_r > SLOT_W'(LAST_SLOT)) begin
      start_eff = SLOT_W'(LAST_SLOT);
    end else begin
      start_eff = start_r;
    end
    diff      = {1'b0, slot_r} - {1'b0, start_eff};
    in_window = (slot_r >= start_eff) && (slot_r <= SLOT_W'(LAST_SLOT))
                && (diff < (SLOT_W + 1)'(CHANNEL_COUNT));
    brk       = in_ch.frame_error | in_ch.overrun;

    cmd.data    = in_ch.rx_byte;
    cmd.cap_idx = diff[CH_IDX_W-1:0];
    cmd.cap_en  = 1'b0;
    slot_nxt    = slot_r;
    if (in_ch.req_type == REQ_TICK) begin
      cmd.op = OP_TICK;
    end else if (brk) begin
      cmd.op   = OP_BREAK;
      slot_nxt = '0;
    end else begin
      cmd.op = OP_BYTE;
      // hold at saturation: bytes past the last slot are dropped
      if (slot_r >= SLOT_W'(SLOT_SATURATE)) begin
        slot_nxt = SLOT_W'(SLOT_SATURATE);
      end else begin
        slot_nxt   = slot_r + SLOT_W'(1);
        cmd.cap_en = in_window;
      end
    end
    cmd.slot = slot_nxt;
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= SLOT_W'(START_RESET);
      slot_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        start_r <= cfg_wr_data;
      end
      if (push) begin
        slot_r <= slot_nxt;
      end
    end
  end

endmodule

/* rtl/dmxd_queue.sv */
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Uses dmxd_pkg for the command type.
module dmxd_queue #(
  parameter int unsigned DEPTH = dmxd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dmxd_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output dmxd_pkg::cmd_t pop_cmd
);
  import dmxd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == CNT_W'(DEPTH));
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;
  assign pop_cmd = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_adv(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_adv(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/dmxd_back.sv */
`timescale 1ns / 1ps
// Back end: applies queued commands to the channel levels and PWM state and
// holds one result beat in an output register. Uses dmxd_pkg, dmxd_out_if.
module dmxd_back #(
  parameter int unsigned CHANNEL_COUNT = dmxd_pkg::CHANNEL_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  dmxd_pkg::cmd_t cmd,
  output logic           pop,
  dmxd_out_if.source     out_ch
);
  import dmxd_pkg::*;

  logic [LEVEL_W-1:0]       levels_r   [CHANNEL_COUNT];
  logic [LEVEL_W-1:0]       levels_nxt [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] drive_r;
  logic [CHANNEL_COUNT-1:0] drive_nxt;
  logic [LEVEL_W-1:0]       phase_r;
  logic [LEVEL_W-1:0]       phase_nxt;
  logic [LEVEL_W-1:0]       phase_inc;
  logic [MAX_CHANNELS-1:0]  drv_pad;
  logic [LEVEL_W-1:0]       lvl_pad    [MAX_CHANNELS];

  logic                     out_valid_r;
  logic [2:0]               out_drive_r;
  logic [LEVEL_W-1:0]       out_level_r [3];
  logic [SLOT_W-1:0]        out_slot_r;

  assign pop = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    phase_inc  = phase_r + LEVEL_W'(1);
    phase_nxt  = phase_r;
    drive_nxt  = drive_r;
    levels_nxt = levels_r;
    if (cmd.op == OP_TICK) begin
      if (phase_inc == LEVEL_W'(PHASE_TOP)) begin
        // wrap: start a new period, turn on every channel with a nonzero level
        phase_nxt = '0;
        for (int k = 0; k < CHANNEL_COUNT; k++) begin
          drive_nxt[k] = (levels_r[k] != '0);
        end
      end else begin
        phase_nxt = phase_inc;
        for (int k = 0; k < CHANNEL_COUNT; k++) begin
          if (levels_r[k] == phase_inc) begin
            drive_nxt[k] = 1'b0;
          end
        end
      end
    end else if (cmd.op == OP_BYTE && cmd.cap_en) begin
      for (int k = 0; k < CHANNEL_COUNT; k++) begin
        if (cmd.cap_idx == CH_IDX_W'(k)) begin
          levels_nxt[k] = cmd.data;
        end
      end
    end

    // missing channels read as zero
    drv_pad = '0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      lvl_pad[k] = '0;
    end
    for (int k = 0; k < CHANNEL_COUNT; k++) begin
      drv_pad[k] = drive_nxt[k];
      lvl_pad[k] = levels_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      drive_r     <= '0;
      for (int k = 0; k < CHANNEL_COUNT; k++) begin
        levels_r[k] <= '0;
      end
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        drive_r     <= drive_nxt;
        levels_r    <= levels_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_drive_r <= drv_pad[2:0];
      for (int k = 0; k < 3; k++) begin
        out_level_r[k] <= lvl_pad[k];
      end
      out_slot_r <= cmd.slot;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive_one     = out_drive_r[0];
  assign out_ch.drive_two     = out_drive_r[1];
  assign out_ch.drive_three   = out_drive_r[2];
  assign out_ch.level_one     = out_level_r[0];
  assign out_ch.level_two     = out_level_r[1];
  assign out_ch.level_three   = out_level_r[2];
  assign out_ch.slot_position = out_slot_r;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for dmx_slot_capture_pwm_dimmer_core: DMX frames and PWM ticks
// against a cycle-free model of slot capture and dimming. Depends on dmxd_pkg, dmxd_in_if,
// dmxd_out_if and the core itself.
module tb_top;
  import dmxd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;

  typedef struct packed {
    req_t               kind;
    logic [LEVEL_W-1:0] data;
    logic               fe;
    logic               ov;
  } dimmer_req_t;

  typedef struct packed {
    logic [2:0]         drv;
    logic [LEVEL_W-1:0] lvl_one;
    logic [LEVEL_W-1:0] lvl_two;
    logic [LEVEL_W-1:0] lvl_three;
    logic [SLOT_W-1:0]  slot;
  } dimmer_view_t;

  typedef struct packed {
    dimmer_req_t  req;
    logic         typed;
    dimmer_view_t want;
  } script_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [SLOT_W-1:0]   cfg_wr_data;

  dmxd_in_if  in_ch();
  dmxd_out_if out_ch();

  dmx_slot_capture_pwm_dimmer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Model state of the dimmer
  logic [SLOT_W-1:0]  start_reg = SLOT_W'(START_RESET);
  logic [SLOT_W-1:0]  slot_ctr = '0;
  logic [LEVEL_W-1:0] levels [3] = '{default: '0};
  logic [LEVEL_W-1:0] pwm_phase = '0;
  logic [2:0]         drive_bits = '0;

  dimmer_view_t pending_views [$];
  script_row_t  script_rows [$];

  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned start_settings = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results still pending", cycles,
                 pending_views.size());
        $display("FAIL dmx_slot_capture_pwm_dimmer_core");
        $finish;
      end
    end
  end

  function automatic dimmer_view_t dimmer_next_view(dimmer_req_t r);
    int unsigned  first;
    int unsigned  k;
    dimmer_view_t v;
    first = (start_reg == '0) ? 1 : ((start_reg > LAST_SLOT) ? LAST_SLOT : start_reg);
    if (r.kind == REQ_TICK) begin
      if (pwm_phase == 8'(PHASE_TOP - 1)) begin
        // wrap: every lit channel starts a new on phase
        pwm_phase = '0;
        for (k = 0; k < 3; k++) drive_bits[k] = (levels[k] != '0);
      end else begin
        pwm_phase = pwm_phase + 8'd1;
        for (k = 0; k < 3; k++) if (levels[k] == pwm_phase) drive_bits[k] = 1'b0;
      end
    end else if (r.fe || r.ov) begin
      slot_ctr = '0;
    end else if (slot_ctr < SLOT_SATURATE) begin
      if (slot_ctr >= 1 && slot_ctr <= LAST_SLOT) begin
        for (k = 0; k < 3; k++) if (int'(slot_ctr) == first + k) levels[k] = r.data;
      end
      slot_ctr = slot_ctr + 1'b1;
    end
    v.drv       = drive_bits;
    v.lvl_one   = levels[0];
    v.lvl_two   = levels[1];
    v.lvl_three = levels[2];
    v.slot      = slot_ctr;
    return v;
  endfunction

  function automatic script_row_t mk_row(req_t kind, logic [7:0] data, logic fe, logic ov,
                                         logic typed, logic [2:0] drv, logic [7:0] l1,
                                         logic [7:0] l2, logic [7:0] l3, logic [9:0] slot);
    script_row_t row;
    row.req   = '{kind: kind, data: data, fe: fe, ov: ov};
    row.typed = typed;
    row.want  = '{drv: drv, lvl_one: l1, lvl_two: l2, lvl_three: l3, slot: slot};
    return row;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] result %0d: %s got %0d expected %0d", $time, results_seen, what, got,
             want);
    mismatches++;
  endtask

  // Called at a rising edge; returns at the edge that takes the beat.
  task automatic send_beat(dimmer_req_t r, logic typed, dimmer_view_t want);
    dimmer_view_t v;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= r.kind;
    in_ch.rx_byte     <= r.data;
    in_ch.frame_error <= r.fe;
    in_ch.overrun     <= r.ov;
    do @(negedge clk); while (in_ch.ready !== 1'b1);
    @(posedge clk);
    v = dimmer_next_view(r);
    pending_views.push_back(typed ? want : v);
    beats_sent++;
    if (r.kind == REQ_TICK) ticks_sent++;
  endtask

  task automatic send_tick();
    dimmer_req_t r;
    // flags and data ride along as junk on a tick
    r = '{kind: REQ_TICK, data: 8'($urandom), fe: 1'($urandom), ov: 1'($urandom)};
    send_beat(r, 1'b0, '0);
  endtask

  task automatic send_frame(int unsigned nbytes, int unsigned tick_pct);
    dimmer_req_t r;
    int unsigned flags;
    flags = $urandom_range(1, 3);
    r = '{kind: REQ_BYTE, data: 8'($urandom), fe: flags[0], ov: flags[1]};
    send_beat(r, 1'b0, '0);
    r.fe   = 1'b0;
    r.ov   = 1'b0;
    r.data = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
    send_beat(r, 1'b0, '0);
    repeat (nbytes) begin
      if ($urandom_range(0, 99) < tick_pct) send_tick();
      r.data = 8'($urandom);
      send_beat(r, 1'b0, '0);
    end
  endtask

  // Loose bytes and ticks with no frame structure, breaks now and then.
  task automatic send_noise(int unsigned n);
    dimmer_req_t r;
    repeat (n) begin
      r.kind = req_t'($urandom_range(0, 1));
      r.data = 8'($urandom);
      r.fe   = ($urandom_range(0, 3) == 0);
      r.ov   = ($urandom_range(0, 3) == 0);
      send_beat(r, 1'b0, '0);
    end
  endtask

  // Drop valid and hold until every pending result is back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  task automatic program_start(logic [SLOT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    start_reg = value;
    start_settings++;
  endtask

  task automatic run_phase(logic [SLOT_W-1:0] start, int unsigned frames,
                           int unsigned max_bytes, int unsigned long_bytes,
                           int unsigned tick_pct, bit gaps, bit stalls);
    settle();
    program_start(start);
    gaps_on   = gaps;
    stalls_on = stalls;
    if (long_bytes != 0) send_frame(long_bytes, tick_pct);
    repeat (frames) begin
      if ($urandom_range(0, 7) == 0) send_noise($urandom_range(1, 6));
      else send_frame($urandom_range(0, max_bytes), tick_pct);
    end
  endtask

  initial begin : sink_pacing
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= (stall_left == 0);
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare at the falling edge; the beat is taken at the next rising edge.
  initial begin : result_check
    dimmer_view_t want;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_views.size() == 0) begin
          report_mismatch("result with nothing pending, slot", out_ch.slot_position, 0);
        end else begin
          want = pending_views.pop_front();
          if (out_ch.drive_one !== want.drv[0])
            report_mismatch("drive_one", out_ch.drive_one, want.drv[0]);
          if (out_ch.drive_two !== want.drv[1])
            report_mismatch("drive_two", out_ch.drive_two, want.drv[1]);
          if (out_ch.drive_three !== want.drv[2])
            report_mismatch("drive_three", out_ch.drive_three, want.drv[2]);
          if (out_ch.level_one !== want.lvl_one)
            report_mismatch("level_one", out_ch.level_one, want.lvl_one);
          if (out_ch.level_two !== want.lvl_two)
            report_mismatch("level_two", out_ch.level_two, want.lvl_two);
          if (out_ch.level_three !== want.lvl_three)
            report_mismatch("level_three", out_ch.level_three, want.lvl_three);
          if (out_ch.slot_position !== want.slot)
            report_mismatch("slot_position", out_ch.slot_position, want.slot);
        end
        results_seen++;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_BYTE;
    in_ch.rx_byte     = '0;
    in_ch.frame_error = 1'b0;
    in_ch.overrun     = 1'b0;

    // Start address 1 from reset. Typed rows: reset state, breaks, capture at slots 1..3.
    script_rows.push_back(mk_row(REQ_TICK, 8'hFF, 1, 1, 1, 3'b000, 8'h00, 8'h00, 8'h00, 0));
    script_rows.push_back(mk_row(REQ_BYTE, 8'hA5, 1, 0, 1, 3'b000, 8'h00, 8'h00, 8'h00, 0));
    script_rows.push_back(mk_row(REQ_BYTE, 8'h5A, 0, 1, 1, 3'b000, 8'h00, 8'h00, 8'h00, 0));
    script_rows.push_back(mk_row(REQ_BYTE, 8'hFF, 1, 1, 1, 3'b000, 8'h00, 8'h00, 8'h00, 0));
    script_rows.push_back(mk_row(REQ_BYTE, 8'hCC, 0, 0, 1, 3'b000, 8'h00, 8'h00, 8'h00, 1));
    script_rows.push_back(mk_row(REQ_BYTE, 8'hFF, 0, 0, 1, 3'b000, 8'hFF, 8'h00, 8'h00, 2));
    script_rows.push_back(mk_row(REQ_BYTE, 8'h00, 0, 0, 1, 3'b000, 8'hFF, 8'h00, 8'h00, 3));
    script_rows.push_back(mk_row(REQ_BYTE, 8'h80, 0, 0, 1, 3'b000, 8'hFF, 8'h00, 8'h80, 4));
    script_rows.push_back(mk_row(REQ_BYTE, 8'h3C, 0, 0, 1, 3'b000, 8'hFF, 8'h00, 8'h80, 5));
    script_rows.push_back(mk_row(REQ_TICK, 8'h00, 0, 0, 1, 3'b000, 8'hFF, 8'h00, 8'h80, 5));
    script_rows.push_back(mk_row(REQ_BYTE, 8'h00, 1, 0, 1, 3'b000, 8'hFF, 8'h00, 8'h80, 0));
    script_rows.push_back(mk_row(REQ_BYTE, 8'h00, 0, 0, 1, 3'b000, 8'hFF, 8'h00, 8'h80, 1));
    script_rows.push_back(mk_row(REQ_BYTE, 8'h02, 0, 0, 1, 3'b000, 8'h02, 8'h00, 8'h80, 2));
    script_rows.push_back(mk_row(REQ_BYTE, 8'h01, 0, 0, 1, 3'b000, 8'h02, 8'h01, 8'h80, 3));
    script_rows.push_back(mk_row(REQ_BYTE, 8'hFF, 0, 0, 1, 3'b000, 8'h02, 8'h01, 8'hFF, 4));
    script_rows.push_back(mk_row(REQ_TICK, 8'h6B, 0, 1, 0, 3'b000, 8'h00, 8'h00, 8'h00, 0));
    script_rows.push_back(mk_row(REQ_TICK, 8'h94, 1, 0, 0, 3'b000, 8'h00, 8'h00, 8'h00, 0));
    script_rows.push_back(mk_row(REQ_BYTE, 8'h77, 0, 0, 0, 3'b000, 8'h00, 8'h00, 8'h00, 0));
    script_rows.push_back(mk_row(REQ_BYTE, 8'h00, 0, 1, 1, 3'b000, 8'h02, 8'h01, 8'hFF, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    foreach (script_rows[i]) send_beat(script_rows[i].req, script_rows[i].typed,
                                       script_rows[i].want);

    run_phase(10'd3, 3, 8, 0, 50, 1'b1, 1'b1);
    run_phase(10'd0, 2, 6, 0, 50, 1'b1, 1'b0);
    // one full universe: capture at the last slot, then saturate past it
    run_phase(10'd1023, 0, 6, 514, 1, 1'b1, 1'b1);
    run_phase(10'd512, 1, 6, 0, 50, 1'b0, 1'b1);
    run_phase(10'd1, 3, 6, 0, 50, 1'b0, 1'b0);

    settle();
    repeat (8) @(posedge clk);

    $display("run covered %0d input beats (%0d PWM ticks), %0d results checked", beats_sent,
             ticks_sent, results_seen);
    $display("start address programmed %0d times, %0d mismatches", start_settings,
             mismatches);
    if (mismatches == 0) begin
      $display("PASS dmx_slot_capture_pwm_dimmer_core");
    end else begin
      $display("FAIL dmx_slot_capture_pwm_dimmer_core");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dmxd_pkg.sv
rtl/dmxd_in_if.sv
rtl/dmxd_out_if.sv
rtl/dmxd_front.sv
rtl/dmxd_queue.sv
rtl/dmxd_back.sv
rtl/dmx_slot_capture_pwm_dimmer_core.sv
verif/tb_top.sv
